// ----- rtl/mef_pkg.sv -----
// shared constants, types and control store of the multitap echo filter
`timescale 1ns / 1ps
`default_nettype none

package mef_pkg;

	// default parameter values
	localparam int DEF_HISTORY_DEPTH = 4096;
	localparam int DEF_TAP_COUNT     = 4;
	localparam int DEF_SAMPLE_BITS   = 24;

	// fixed field formats
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 15;
	localparam int DLY_W      = 12;
	localparam int MAX_TAPS   = 4;
	localparam int TAP_IDX_W  = 2;
	localparam int CFG_DATA_W = MAX_TAPS * DLY_W;
	localparam int CFG_IDX_W  = 3;

	// register reset values
	localparam logic signed [GAIN_W-1:0] RST_DRY_GAIN = 16'sd16384;
	localparam logic signed [GAIN_W-1:0] RST_ECHO_GAIN [MAX_TAPS] =
		'{16'sd8192, 16'sd4096, 16'sd2048, 16'sd2048};
	localparam logic [CFG_DATA_W-1:0] RST_TAP_DELAYS = {12'd3072, 12'd2560, 12'd1536, 12'd1024};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRY_GAIN    = 3'd0,
		REG_ECHO_GAIN_0 = 3'd1,
		REG_ECHO_GAIN_1 = 3'd2,
		REG_ECHO_GAIN_2 = 3'd3,
		REG_ECHO_GAIN_3 = 3'd4,
		REG_TAP_DELAYS  = 3'd5
	} reg_idx_t;

	// sequencer
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_FIRST = 3'd1;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT,
		JMP_DONE
	} jmp_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_DRY,
		MUL_TAP
	} mul_op_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		jmp_t                 jmp;
		logic [STEP_W-1:0]    target;
		logic                 mem_wr;
		logic                 ptr_adv;
		logic                 dly_ld;
		logic [TAP_IDX_W-1:0] dly_tap;
		logic                 rd_en;
		logic [TAP_IDX_W-1:0] rd_tap;
		mul_op_t              mul_op;
		logic [TAP_IDX_W-1:0] mul_tap;
		acc_op_t              acc_op;
		logic                 out_ld;
	} ucode_t;

	// one control word per step: write, four overlapped tap reads, mac drain
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t uc;
		uc = '0;
		unique case (step)
			3'd0: begin
				uc.jmp    = JMP_WAIT;
				uc.target = STEP_FIRST;
			end
			3'd1: begin
				uc.mem_wr  = 1'b1;
				uc.dly_ld  = 1'b1;
				uc.dly_tap = 2'd0;
				uc.mul_op  = MUL_DRY;
			end
			3'd2: begin
				uc.rd_en   = 1'b1;
				uc.rd_tap  = 2'd0;
				uc.dly_ld  = 1'b1;
				uc.dly_tap = 2'd1;
				uc.acc_op  = ACC_LOAD;
			end
			3'd3: begin
				uc.rd_en   = 1'b1;
				uc.rd_tap  = 2'd1;
				uc.dly_ld  = 1'b1;
				uc.dly_tap = 2'd2;
				uc.mul_op  = MUL_TAP;
				uc.mul_tap = 2'd0;
			end
			3'd4: begin
				uc.rd_en   = 1'b1;
				uc.rd_tap  = 2'd2;
				uc.dly_ld  = 1'b1;
				uc.dly_tap = 2'd3;
				uc.mul_op  = MUL_TAP;
				uc.mul_tap = 2'd1;
				uc.acc_op  = ACC_ADD;
			end
			3'd5: begin
				uc.rd_en   = 1'b1;
				uc.rd_tap  = 2'd3;
				uc.ptr_adv = 1'b1;
				uc.mul_op  = MUL_TAP;
				uc.mul_tap = 2'd2;
				uc.acc_op  = ACC_ADD;
			end
			3'd6: begin
				uc.mul_op  = MUL_TAP;
				uc.mul_tap = 2'd3;
				uc.acc_op  = ACC_ADD;
			end
			3'd7: begin
				uc.jmp    = JMP_DONE;
				uc.target = STEP_FIRST;
				uc.out_ld = 1'b1;
			end
			default: begin
				uc.jmp    = JMP_WAIT;
				uc.target = STEP_FIRST;
			end
		endcase
		return uc;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/multitap_echo_filter_unit.sv -----
// multitap echo filter: microcoded sequencer around a single-port history memory
// samples are not overlapped: a new one is taken only while idle or in the output step,
//   since the one history memory port (one write plus four tap reads) is followed
//   by the multiply-accumulate drain
// reset: gains and delays return to defaults, write pointer to the last entry;
//   a fill count makes never-written history read as zero, so there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module multitap_echo_filter_unit #(
	parameter int HISTORY_DEPTH = mef_pkg::DEF_HISTORY_DEPTH,
	parameter int TAP_COUNT     = mef_pkg::DEF_TAP_COUNT,
	parameter int SAMPLE_BITS   = mef_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mef_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mef_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]          sample_out
);

	import mef_pkg::*;

	localparam int AW     = $clog2(HISTORY_DEPTH);
	localparam int FW     = $clog2(HISTORY_DEPTH + 1);
	localparam int PROD_W = SAMPLE_BITS + GAIN_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam bit REDUCE = HISTORY_DEPTH < (1 << DLY_W);

	localparam logic signed [ACC_W-1:0] SAT_HI =
		ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	// configuration registers
	logic signed [GAIN_W-1:0] dry_gain_q;
	logic signed [GAIN_W-1:0] echo_gain_q [MAX_TAPS];
	logic [CFG_DATA_W-1:0]    tap_delays_q;

	// sequencer
	logic [STEP_W-1:0] step_q, step_d;
	ucode_t            uc;
	logic              in_acc, out_free;

	// datapath
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [AW-1:0]                 wi_q;
	logic [FW-1:0]                 fill_q;
	logic [SAMPLE_BITS-1:0]        mem [HISTORY_DEPTH];
	logic [SAMPLE_BITS-1:0]        rd_data_q;
	logic                          rd_ok_q;
	logic [DLY_W-1:0]              dly_sel;
	logic [AW-1:0]                 dm;
	logic [AW:0]                   rd_diff;
	logic [AW-1:0]                 rd_addr;
	logic                          rd_ok;
	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic signed [GAIN_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       sum, floored;
	logic signed [SAMPLE_BITS-1:0] sat;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_gain_q   <= RST_DRY_GAIN;
			echo_gain_q  <= RST_ECHO_GAIN;
			tap_delays_q <= RST_TAP_DELAYS;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_DRY_GAIN: dry_gain_q <= cfg_data[GAIN_W-1:0];
				REG_ECHO_GAIN_0, REG_ECHO_GAIN_1, REG_ECHO_GAIN_2, REG_ECHO_GAIN_3:
					echo_gain_q[TAP_IDX_W'(cfg_index - CFG_IDX_W'(REG_ECHO_GAIN_0))] <=
						cfg_data[GAIN_W-1:0];
				REG_TAP_DELAYS: tap_delays_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control store and step counter
	assign uc       = ucode_rom(step_q);
	assign out_free = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		in_ready = 1'b0;
		unique case (uc.jmp)
			JMP_WAIT: in_ready = 1'b1;
			JMP_DONE: in_ready = out_free;
			default:  in_ready = 1'b0;
		endcase
	end

	always_comb begin
		step_d = step_q;
		unique case (uc.jmp)
			JMP_NEXT: step_d = step_q + STEP_W'(1);
			JMP_WAIT: step_d = in_acc ? uc.target : step_q;
			JMP_DONE: begin
				if (out_free)
					step_d = in_acc ? uc.target : STEP_IDLE;
			end
			default: step_d = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_IDLE;
		else
			step_q <= step_d;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			x_q <= sample_in;
	end

	// write pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q   <= AW'(HISTORY_DEPTH - 1);
			fill_q <= '0;
		end else begin
			if (uc.ptr_adv)
				wi_q <= (wi_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wi_q + AW'(1);
			if (uc.mem_wr && fill_q != FW'(HISTORY_DEPTH))
				fill_q <= fill_q + FW'(1);
		end
	end

	// delay reduction modulo the history depth, registered in the step before the read
	assign dly_sel = tap_delays_q[uc.dly_tap * DLY_W +: DLY_W];

	generate
		if (REDUCE) begin : g_mod
			localparam int      RECIP_SH = 24;
			localparam longint  RECIP    = ((64'd1 << RECIP_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
			localparam int      RECIP_W  = $clog2(RECIP + 1);
			localparam int      RP_W     = DLY_W + RECIP_W;
			localparam int      QW       = $clog2(((1 << DLY_W) - 1) / HISTORY_DEPTH + 1);

			logic [RP_W-1:0]  rprod;
			logic [QW-1:0]    quo_q;
			logic [DLY_W-1:0] dly_q;
			logic [DLY_W-1:0] qd;

			assign rprod = RP_W'(dly_sel) * RP_W'(RECIP);

			always_ff @(posedge clk) begin
				if (uc.dly_ld) begin
					quo_q <= QW'(rprod >> RECIP_SH);
					dly_q <= dly_sel;
				end
			end

			assign qd = DLY_W'(quo_q) * DLY_W'(HISTORY_DEPTH);
			assign dm = AW'(dly_q - qd);
		end else begin : g_pass
			logic [DLY_W-1:0] dly_q;

			always_ff @(posedge clk) begin
				if (uc.dly_ld)
					dly_q <= dly_sel;
			end

			assign dm = AW'(dly_q);
		end
	endgenerate

	// tap address, wrapped into the circular store
	assign rd_diff = {1'b0, wi_q} - {1'b0, dm};
	assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(HISTORY_DEPTH)) : rd_diff[AW-1:0];
	// entries older than the fill count were never written and read as zero
	assign rd_ok   = (FW'(dm) < fill_q) && ({1'b0, uc.rd_tap} < (TAP_IDX_W+1)'(TAP_COUNT));

	// single-port history memory
	always_ff @(posedge clk) begin
		if (uc.mem_wr)
			mem[wi_q] <= x_q;
		else if (uc.rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (uc.rd_en)
			rd_ok_q <= rd_ok;
	end

	// multiply-accumulate
	assign mul_a = (uc.mul_op == MUL_DRY) ? x_q : (rd_ok_q ? rd_data_q : '0);
	assign mul_b = (uc.mul_op == MUL_DRY) ? dry_gain_q : echo_gain_q[uc.mul_tap];

	always_ff @(posedge clk) begin
		if (uc.mul_op != MUL_NONE)
			prod_q <= mul_a * mul_b;
		case (uc.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  ;
		endcase
	end

	// last tap folds in here, then floor and clamp
	assign sum     = acc_q + ACC_W'(prod_q);
	assign floored = sum >>> GAIN_FRAC;

	always_comb begin
		if (floored > SAT_HI)
			sat = SAT_HI[SAMPLE_BITS-1:0];
		else if (floored < SAT_LO)
			sat = SAT_LO[SAMPLE_BITS-1:0];
		else
			sat = floored[SAMPLE_BITS-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (uc.out_ld && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (uc.out_ld && out_free)
			sample_out_q <= sat;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

`default_nettype wire

// ----- rtl/mef_checker.sv -----
// port-level checks of the multitap echo filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mef_checker #(
	parameter int SAMPLE_BITS = mef_pkg::DEF_SAMPLE_BITS
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [SAMPLE_BITS-1:0] sample_out
);

	// transactions taken in but not yet delivered
	logic [2:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (in_acc && !out_acc)
			pend_q <= pend_q + 3'd1;
		else if (out_acc && !in_acc)
			pend_q <= pend_q - 3'd1;
	end

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid && in_ready)
		else $error("outputs not quiet in reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("stalled result changed");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("took a transaction while the previous one starts");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without a pending transaction");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more than two transactions in flight");

endmodule

bind multitap_echo_filter_unit mef_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_mef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample_out(sample_out)
);

`default_nettype wire
